FILE: rtl/c6502_pkg.sv
// Shared types and constants for the 6502 execute stage.
// Used by c6502_execute, c6502_regfile and cpu6502_register_alu_execute.
package c6502_pkg;

    // status register bit positions: N V U B D I Z C, bit 7 down to bit 0
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_B = 4;
    localparam int unsigned FLAG_U = 5;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam logic [7:0] RESET_A  = 8'h00;
    localparam logic [7:0] RESET_X  = 8'h00;
    localparam logic [7:0] RESET_Y  = 8'h00;
    localparam logic [7:0] RESET_SP = 8'hFD;
    localparam logic [7:0] RESET_P  = 8'h20;

    typedef enum logic [5:0] {
        OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_EOR = 6'd3,
        OP_ORA = 6'd4,  OP_ASL = 6'd5,  OP_LSR = 6'd6,  OP_ROL = 6'd7,
        OP_ROR = 6'd8,  OP_CMP = 6'd9,  OP_CPX = 6'd10, OP_CPY = 6'd11,
        OP_BIT = 6'd12, OP_INC = 6'd13, OP_DEC = 6'd14, OP_INX = 6'd15,
        OP_INY = 6'd16, OP_DEX = 6'd17, OP_DEY = 6'd18, OP_LDA = 6'd19,
        OP_LDX = 6'd20, OP_LDY = 6'd21, OP_STA = 6'd22, OP_STX = 6'd23,
        OP_STY = 6'd24, OP_TAX = 6'd25, OP_TAY = 6'd26, OP_TSX = 6'd27,
        OP_TXA = 6'd28, OP_TXS = 6'd29, OP_TYA = 6'd30, OP_CLC = 6'd31,
        OP_CLD = 6'd32, OP_CLI = 6'd33, OP_CLV = 6'd34, OP_SEC = 6'd35,
        OP_SED = 6'd36, OP_SEI = 6'd37, OP_BCC = 6'd38, OP_BCS = 6'd39,
        OP_BEQ = 6'd40, OP_BMI = 6'd41, OP_BNE = 6'd42, OP_BPL = 6'd43,
        OP_BVC = 6'd44, OP_BVS = 6'd45, OP_PHA = 6'd46, OP_PHP = 6'd47,
        OP_PLA = 6'd48, OP_PLP = 6'd49, OP_NOP = 6'd50
    } op_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } regs_t;

    typedef struct packed {
        logic [7:0] write_data;
        logic       write_enable;
        logic       write_to_stack;
        logic       branch_taken;
    } exec_res_t;

endpackage

FILE: rtl/c6502_execute.sv
// Combinational execute step: one operation against the register set.
// Depends on c6502_pkg for the operation codes, flag positions and structs.
module c6502_execute
    import c6502_pkg::*;
(
    input  op_t        op,
    input  logic [7:0] operand,
    input  logic       acc_mode,
    input  regs_t      regs,
    output regs_t      regs_next,
    output exec_res_t  res
);

    always_comb begin
        regs_t      r;
        logic [8:0] sum;
        logic [7:0] addend;
        logic [7:0] src;
        logic [7:0] shf;
        logic [7:0] cmp_reg;
        logic [7:0] diff;
        logic       cin;

        r        = regs;
        r.p[FLAG_U] = 1'b1;
        res      = '0;
        cin      = r.p[FLAG_C];
        addend   = (op == OP_SBC) ? ~operand : operand;
        sum      = {1'b0, r.a} + {1'b0, addend} + {8'd0, cin};
        src      = acc_mode ? r.a : operand;
        shf      = '0;
        cmp_reg  = r.a;
        diff     = '0;

        unique case (op)
            OP_ADC, OP_SBC: begin
                r.p[FLAG_C] = sum[8];
                r.p[FLAG_V] = ~(r.a[7] ^ addend[7]) & (r.a[7] ^ sum[7]);
                r.a         = sum[7:0];
                r.p[FLAG_Z] = (sum[7:0] == 8'd0);
                r.p[FLAG_N] = sum[7];
            end
            OP_AND, OP_EOR, OP_ORA, OP_LDA, OP_TXA, OP_TYA, OP_PLA: begin
                unique case (op)
                    OP_AND:  r.a = r.a & operand;
                    OP_EOR:  r.a = r.a ^ operand;
                    OP_ORA:  r.a = r.a | operand;
                    OP_TXA:  r.a = r.x;
                    OP_TYA:  r.a = r.y;
                    default: r.a = operand;
                endcase
                if (op == OP_PLA) begin
                    r.sp = r.sp + 8'd1;
                end
                r.p[FLAG_Z] = (r.a == 8'd0);
                r.p[FLAG_N] = r.a[7];
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                unique case (op)
                    OP_ASL:  shf = {src[6:0], 1'b0};
                    OP_LSR:  shf = {1'b0, src[7:1]};
                    OP_ROL:  shf = {src[6:0], cin};
                    default: shf = {cin, src[7:1]};
                endcase
                r.p[FLAG_C] = (op == OP_ASL || op == OP_ROL) ? src[7] : src[0];
                r.p[FLAG_Z] = (shf == 8'd0);
                r.p[FLAG_N] = shf[7];
                if (acc_mode) begin
                    r.a = shf;
                end else begin
                    res.write_data   = shf;
                    res.write_enable = 1'b1;
                end
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                unique case (op)
                    OP_CPX:  cmp_reg = r.x;
                    OP_CPY:  cmp_reg = r.y;
                    default: cmp_reg = r.a;
                endcase
                diff        = cmp_reg - operand;
                r.p[FLAG_C] = (cmp_reg >= operand);
                r.p[FLAG_Z] = (diff == 8'd0);
                r.p[FLAG_N] = diff[7];
            end
            OP_BIT: begin
                r.p[FLAG_Z] = ((r.a & operand) == 8'd0);
                r.p[FLAG_N] = operand[7];
                r.p[FLAG_V] = operand[6];
            end
            OP_INC, OP_DEC: begin
                res.write_data   = (op == OP_INC) ? operand + 8'd1 : operand - 8'd1;
                res.write_enable = 1'b1;
                r.p[FLAG_Z]      = (res.write_data == 8'd0);
                r.p[FLAG_N]      = res.write_data[7];
            end
            OP_INX, OP_DEX, OP_LDX, OP_TAX, OP_TSX: begin
                unique case (op)
                    OP_INX:  r.x = r.x + 8'd1;
                    OP_DEX:  r.x = r.x - 8'd1;
                    OP_LDX:  r.x = operand;
                    OP_TAX:  r.x = r.a;
                    default: r.x = r.sp;
                endcase
                r.p[FLAG_Z] = (r.x == 8'd0);
                r.p[FLAG_N] = r.x[7];
            end
            OP_INY, OP_DEY, OP_LDY, OP_TAY: begin
                unique case (op)
                    OP_INY:  r.y = r.y + 8'd1;
                    OP_DEY:  r.y = r.y - 8'd1;
                    OP_LDY:  r.y = operand;
                    default: r.y = r.a;
                endcase
                r.p[FLAG_Z] = (r.y == 8'd0);
                r.p[FLAG_N] = r.y[7];
            end
            OP_STA: begin
                res.write_data   = r.a;
                res.write_enable = 1'b1;
            end
            OP_STX: begin
                res.write_data   = r.x;
                res.write_enable = 1'b1;
            end
            OP_STY: begin
                res.write_data   = r.y;
                res.write_enable = 1'b1;
            end
            OP_TXS: r.sp = r.x;
            OP_CLC: r.p[FLAG_C] = 1'b0;
            OP_CLD: r.p[FLAG_D] = 1'b0;
            OP_CLI: r.p[FLAG_I] = 1'b0;
            OP_CLV: r.p[FLAG_V] = 1'b0;
            OP_SEC: r.p[FLAG_C] = 1'b1;
            OP_SED: r.p[FLAG_D] = 1'b1;
            OP_SEI: r.p[FLAG_I] = 1'b1;
            OP_BCC: res.branch_taken = ~r.p[FLAG_C];
            OP_BCS: res.branch_taken =  r.p[FLAG_C];
            OP_BEQ: res.branch_taken =  r.p[FLAG_Z];
            OP_BMI: res.branch_taken =  r.p[FLAG_N];
            OP_BNE: res.branch_taken = ~r.p[FLAG_Z];
            OP_BPL: res.branch_taken = ~r.p[FLAG_N];
            OP_BVC: res.branch_taken = ~r.p[FLAG_V];
            OP_BVS: res.branch_taken =  r.p[FLAG_V];
            OP_PHA, OP_PHP: begin
                // push goes to page one at sp, then sp moves down
                res.write_data     = (op == OP_PHA) ? r.a
                                   : (r.p | 8'h30);
                res.write_enable   = 1'b1;
                res.write_to_stack = 1'b1;
                if (op == OP_PHP) begin
                    r.p[FLAG_B] = 1'b0;
                end
                r.sp = r.sp - 8'd1;
            end
            OP_PLP: begin
                r.sp        = r.sp + 8'd1;
                r.p         = operand;
                r.p[FLAG_B] = 1'b0;
            end
            default: begin
                // NOP and unassigned codes leave everything alone
            end
        endcase

        r.p[FLAG_U] = 1'b1;
        regs_next   = r;
    end

endmodule

FILE: rtl/c6502_regfile.sv
// Architectural registers A, X, Y, SP and P with their reset values.
// Depends on c6502_pkg for regs_t and the reset constants.
module c6502_regfile
    import c6502_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_en,
    input  regs_t regs_next,
    output regs_t regs
);

    regs_t regs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.a  <= RESET_A;
            regs_reg.x  <= RESET_X;
            regs_reg.y  <= RESET_Y;
            regs_reg.sp <= RESET_SP;
            regs_reg.p  <= RESET_P;
        end else if (wr_en) begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

FILE: rtl/cpu6502_register_alu_execute.sv
// Top level of the 6502 execute stage: input register, execute step, result register.
// Depends on c6502_pkg, c6502_execute and c6502_regfile.
//
//  channel | dir | tdata                        | tuser
//  s_      | in  | [7:0] operand                | [5:0] operation, [6] accumulator_mode
//  m_      | out | write_data, A, X, Y, SP, P,  | [0] write_enable, [1] write_to_stack
//          |     | branch_taken (see port)      |
//
// One item per cycle sustained while m_ does not stall; an accepted item is held
// first in the input register, then in the result register, which drives m_tvalid.
// The item executes as it moves from the input register to the result register,
// and the register file updates on that same edge, so the next item sees it.
// Reset (aresetn low, synchronous) empties both registers and loads A=X=Y=0,
// SP=0xFD, P=0x20.
// A stall on m_ holds the result and the register file; s_tready stays high
// while the input register is empty or drains this cycle.
module cpu6502_register_alu_execute
    import c6502_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] operand
    input  logic [6:0]  s_tuser,   // [5:0] operation, [6] accumulator_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] write_data, [15:8] accumulator_out, [23:16] index_x_out,
    // [31:24] index_y_out, [39:32] stack_pointer_out, [47:40] status_out,
    // [48] branch_taken, [55:49] zero
    output logic [55:0] m_tdata,
    output logic [1:0]  m_tuser    // [0] write_enable, [1] write_to_stack
);

    logic       in_valid_reg;
    logic [5:0] in_op_reg;
    logic [7:0] in_operand_reg;
    logic       in_acc_mode_reg;

    logic        out_valid_reg;
    logic [55:0] out_data_reg;
    logic [1:0]  out_user_reg;

    logic      advance;
    regs_t     regs;
    regs_t     regs_next;
    exec_res_t res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg       <= s_tuser[5:0];
            in_acc_mode_reg <= s_tuser[6];
            in_operand_reg  <= s_tdata;
        end
    end

    c6502_execute u_execute (
        .op        (op_t'(in_op_reg)),
        .operand   (in_operand_reg),
        .acc_mode  (in_acc_mode_reg),
        .regs      (regs),
        .regs_next (regs_next),
        .res       (res)
    );

    c6502_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (advance),
        .regs_next (regs_next),
        .regs      (regs)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {7'd0, res.branch_taken, regs_next.p, regs_next.sp,
                             regs_next.y, regs_next.x, regs_next.a, res.write_data};
            out_user_reg <= {res.write_to_stack, res.write_enable};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // held status keeps U set and B clear at all times
    a_status_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        regs.p[FLAG_U] && !regs.p[FLAG_B])
        else $error("held status lost U or gained B");

    // a stalled result freezes the register file
    a_stall_holds_regs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(regs))
        else $error("register file moved during output stall");

    // stack writes are always real writes
    a_stack_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("write_to_stack without write_enable");

    // branches never write memory
    a_branch_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[48]) |-> !m_tuser[0])
        else $error("branch taken together with a write");

endmodule

FILE: bench/cpu6502_execute_checker.sv
`timescale 1ns / 100ps
// Checker for the 6502 execute stage: watches both stream channels, keeps its own copy
// of A, X, Y, SP and P, predicts every result word and compares it field by field.
// Depends on c6502_pkg.
module cpu6502_execute_checker
    import c6502_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [6:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int unsigned mismatch_count,
    output int unsigned outstanding_count
);

    typedef struct packed {
        logic [7:0] write_data;
        logic       write_enable;
        logic       write_to_stack;
        logic [7:0] a, x, y, sp, p;
        logic       branch_taken;
    } retire_t;

    logic [7:0] cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
    retire_t    retire_q[$];

    initial begin
        mismatch_count = 0;
        outstanding_count = 0;
    end

    function automatic logic [7:0] with_nz(input logic [7:0] flags, input logic [7:0] value);
        flags[FLAG_Z] = (value == 8'h00);
        flags[FLAG_N] = value[7];
        return flags;
    endfunction

    // Execute one operation on the shadow registers and build the word it retires.
    task automatic execute_op(input logic [5:0] code, input logic [7:0] m,
                              input logic acc_mode, output retire_t r);
        logic [8:0] sum;
        logic [7:0] addend;
        logic [7:0] src;
        logic [7:0] res;
        logic [7:0] cmp_reg;
        logic       cin;
        r = '0;
        cpu_p[FLAG_U] = 1'b1;
        case (code)
            OP_ADC, OP_SBC: begin
                // binary only, even with D set
                addend = (code == OP_SBC) ? ~m : m;
                sum = {1'b0, cpu_a} + {1'b0, addend} + {8'h00, cpu_p[FLAG_C]};
                cpu_p[FLAG_C] = sum[8];
                cpu_p[FLAG_V] = ~(cpu_a[7] ^ addend[7]) & (cpu_a[7] ^ sum[7]);
                cpu_a = sum[7:0];
                cpu_p = with_nz(cpu_p, cpu_a);
            end
            OP_AND: begin cpu_a = cpu_a & m; cpu_p = with_nz(cpu_p, cpu_a); end
            OP_EOR: begin cpu_a = cpu_a ^ m; cpu_p = with_nz(cpu_p, cpu_a); end
            OP_ORA: begin cpu_a = cpu_a | m; cpu_p = with_nz(cpu_p, cpu_a); end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                src = acc_mode ? cpu_a : m;
                cin = cpu_p[FLAG_C];
                case (code)
                    OP_ASL:  res = {src[6:0], 1'b0};
                    OP_LSR:  res = {1'b0, src[7:1]};
                    OP_ROL:  res = {src[6:0], cin};
                    default: res = {cin, src[7:1]};
                endcase
                cpu_p[FLAG_C] = (code == OP_ASL || code == OP_ROL) ? src[7] : src[0];
                cpu_p = with_nz(cpu_p, res);
                if (acc_mode) begin
                    cpu_a = res;
                end else begin
                    r.write_data = res;
                    r.write_enable = 1'b1;
                end
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                cmp_reg = (code == OP_CMP) ? cpu_a : (code == OP_CPX) ? cpu_x : cpu_y;
                cpu_p[FLAG_C] = (cmp_reg >= m);
                cpu_p = with_nz(cpu_p, cmp_reg - m);
            end
            OP_BIT: begin
                cpu_p[FLAG_Z] = ((cpu_a & m) == 8'h00);
                cpu_p[FLAG_N] = m[7];
                cpu_p[FLAG_V] = m[6];
            end
            OP_INC, OP_DEC: begin
                res = (code == OP_INC) ? m + 8'd1 : m - 8'd1;
                cpu_p = with_nz(cpu_p, res);
                r.write_data = res;
                r.write_enable = 1'b1;
            end
            OP_INX: begin cpu_x = cpu_x + 8'd1; cpu_p = with_nz(cpu_p, cpu_x); end
            OP_INY: begin cpu_y = cpu_y + 8'd1; cpu_p = with_nz(cpu_p, cpu_y); end
            OP_DEX: begin cpu_x = cpu_x - 8'd1; cpu_p = with_nz(cpu_p, cpu_x); end
            OP_DEY: begin cpu_y = cpu_y - 8'd1; cpu_p = with_nz(cpu_p, cpu_y); end
            OP_LDA: begin cpu_a = m; cpu_p = with_nz(cpu_p, m); end
            OP_LDX: begin cpu_x = m; cpu_p = with_nz(cpu_p, m); end
            OP_LDY: begin cpu_y = m; cpu_p = with_nz(cpu_p, m); end
            OP_STA: begin r.write_data = cpu_a; r.write_enable = 1'b1; end
            OP_STX: begin r.write_data = cpu_x; r.write_enable = 1'b1; end
            OP_STY: begin r.write_data = cpu_y; r.write_enable = 1'b1; end
            OP_TAX: begin cpu_x = cpu_a; cpu_p = with_nz(cpu_p, cpu_x); end
            OP_TAY: begin cpu_y = cpu_a; cpu_p = with_nz(cpu_p, cpu_y); end
            OP_TSX: begin cpu_x = cpu_sp; cpu_p = with_nz(cpu_p, cpu_x); end
            OP_TXA: begin cpu_a = cpu_x; cpu_p = with_nz(cpu_p, cpu_a); end
            OP_TXS: cpu_sp = cpu_x;
            OP_TYA: begin cpu_a = cpu_y; cpu_p = with_nz(cpu_p, cpu_a); end
            OP_CLC: cpu_p[FLAG_C] = 1'b0;
            OP_CLD: cpu_p[FLAG_D] = 1'b0;
            OP_CLI: cpu_p[FLAG_I] = 1'b0;
            OP_CLV: cpu_p[FLAG_V] = 1'b0;
            OP_SEC: cpu_p[FLAG_C] = 1'b1;
            OP_SED: cpu_p[FLAG_D] = 1'b1;
            OP_SEI: cpu_p[FLAG_I] = 1'b1;
            OP_BCC: r.branch_taken = !cpu_p[FLAG_C];
            OP_BCS: r.branch_taken = cpu_p[FLAG_C];
            OP_BEQ: r.branch_taken = cpu_p[FLAG_Z];
            OP_BMI: r.branch_taken = cpu_p[FLAG_N];
            OP_BNE: r.branch_taken = !cpu_p[FLAG_Z];
            OP_BPL: r.branch_taken = !cpu_p[FLAG_N];
            OP_BVC: r.branch_taken = !cpu_p[FLAG_V];
            OP_BVS: r.branch_taken = cpu_p[FLAG_V];
            OP_PHA: begin
                r.write_data = cpu_a;
                r.write_enable = 1'b1;
                r.write_to_stack = 1'b1;
                cpu_sp = cpu_sp - 8'd1;
            end
            OP_PHP: begin
                // pushed copy carries B and U, the held B stays clear
                res = cpu_p;
                res[FLAG_B] = 1'b1;
                res[FLAG_U] = 1'b1;
                r.write_data = res;
                r.write_enable = 1'b1;
                r.write_to_stack = 1'b1;
                cpu_p[FLAG_B] = 1'b0;
                cpu_sp = cpu_sp - 8'd1;
            end
            OP_PLA: begin
                cpu_sp = cpu_sp + 8'd1;
                cpu_a = m;
                cpu_p = with_nz(cpu_p, m);
            end
            OP_PLP: begin
                cpu_sp = cpu_sp + 8'd1;
                cpu_p = m;
                cpu_p[FLAG_B] = 1'b0;
            end
            default: ;
        endcase
        cpu_p[FLAG_U] = 1'b1;
        r.a = cpu_a;
        r.x = cpu_x;
        r.y = cpu_y;
        r.sp = cpu_sp;
        r.p = cpu_p;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %02h, got %02h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        retire_t want;
        if (!aresetn) begin
            cpu_a = RESET_A;
            cpu_x = RESET_X;
            cpu_y = RESET_Y;
            cpu_sp = RESET_SP;
            cpu_p = RESET_P;
            retire_q.delete();
        end else begin
            // retire first, then take in the new word
            if (m_tvalid && m_tready) begin
                if (retire_q.size() == 0) begin
                    $error("result word with no prediction pending");
                    mismatch_count++;
                end else begin
                    want = retire_q.pop_front();
                    check_field("write_data", want.write_data, m_tdata[7:0]);
                    check_field("write_enable", {7'd0, want.write_enable},
                                {7'd0, m_tuser[0]});
                    check_field("write_to_stack", {7'd0, want.write_to_stack},
                                {7'd0, m_tuser[1]});
                    check_field("accumulator_out", want.a, m_tdata[15:8]);
                    check_field("index_x_out", want.x, m_tdata[23:16]);
                    check_field("index_y_out", want.y, m_tdata[31:24]);
                    check_field("stack_pointer_out", want.sp, m_tdata[39:32]);
                    check_field("status_out", want.p, m_tdata[47:40]);
                    check_field("branch_taken", {7'd0, want.branch_taken},
                                {7'd0, m_tdata[48]});
                    check_field("tdata_padding", 8'h00, {1'b0, m_tdata[55:49]});
                end
            end
            if (s_tvalid && s_tready) begin
                execute_op(s_tuser[5:0], s_tdata, s_tuser[6], want);
                retire_q.push_back(want);
            end
        end
        outstanding_count = retire_q.size();
    end

endmodule

FILE: bench/tb_cpu6502_register_alu_execute.sv
`timescale 1ns / 100ps
// Testbench top for cpu6502_register_alu_execute: clock, reset, stream stimulus and verdict.
// Depends on c6502_pkg, the execute stage RTL and cpu6502_execute_checker.
module tb_cpu6502_register_alu_execute;
    import c6502_pkg::*;

    localparam logic [5:0]  OP_SPARE_LOW  = 6'd51;
    localparam logic [5:0]  OP_SPARE_HIGH = 6'd63;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned PHASE_WORDS   = 400;

    // pacing of the two channels; the receiver reads it at every word
    typedef enum logic [1:0] {
        PACE_RANDOM, PACE_FULL, PACE_SENDER_BURST, PACE_RECEIVER_BURST
    } pace_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [6:0]  s_tuser = 7'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    int unsigned mismatch_count;
    int unsigned outstanding_count;
    int unsigned cycle_count = 0;
    pace_t       pace = PACE_RANDOM;
    logic        long_hold_req = 1'b0;
    logic [7:0]  corner_bytes[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};

    cpu6502_register_alu_execute u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cpu6502_execute_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .mismatch_count    (mismatch_count),
        .outstanding_count (outstanding_count)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stall per word, none in full or receiver-burst pace; once a long hold.
    initial begin
        int unsigned stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end else if (pace == PACE_FULL || pace == PACE_RECEIVER_BURST) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 19);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offer one word; valid stays high into the next word when no gap is drawn.
    task automatic issue_op(input logic [5:0] code, input logic [7:0] operand,
                            input logic acc_mode);
        int unsigned gap;
        gap = (pace == PACE_FULL || pace == PACE_SENDER_BURST) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= operand;
        s_tuser <= {acc_mode, code};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic issue_random_op();
        logic [5:0] code;
        logic [7:0] operand;
        if ($urandom_range(0, 9) == 0)
            code = 6'($urandom_range(OP_SPARE_LOW, OP_SPARE_HIGH));
        else
            code = 6'($urandom_range(OP_ADC, OP_NOP));
        if ($urandom_range(0, 4) == 0)
            operand = corner_bytes[2'($urandom_range(0, 3))];
        else
            operand = 8'($urandom_range(0, 255));
        issue_op(code, operand, 1'($urandom_range(0, 1)));
    endtask

    // Drop valid and hold until every predicted word has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding_count != 0);
        @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        issue_op(OP_LDA, 8'h7F, 1'b1);     // accumulator mode ignored off shifts
        issue_op(OP_ADC, 8'h01, 1'b0);     // signed overflow into negative
        issue_op(OP_ADC, 8'hFF, 1'b0);     // carry out
        issue_op(OP_SBC, 8'h80, 1'b0);
        issue_op(OP_SED, 8'h00, 1'b0);
        issue_op(OP_ADC, 8'h09, 1'b0);     // decimal flag set, sum stays binary
        issue_op(OP_PHP, 8'h00, 1'b0);     // pushed status carries break bit
        issue_op(OP_PLP, 8'hFF, 1'b0);     // pulled break bit dropped
        issue_op(OP_PLP, 8'h00, 1'b0);     // unused bit forced back on
        issue_op(OP_LDX, 8'h00, 1'b0);
        issue_op(OP_TXS, 8'h00, 1'b0);
        issue_op(OP_PHA, 8'h00, 1'b0);     // stack pointer wraps down to FF
        issue_op(OP_PLA, 8'h80, 1'b0);     // and back up to 00
        issue_op(OP_BMI, 8'h00, 1'b0);
        issue_op(OP_ASL, 8'hFF, 1'b0);
        issue_op(OP_ROR, 8'h00, 1'b1);
        issue_op(OP_ROL, 8'h00, 1'b0);
        issue_op(OP_LSR, 8'h01, 1'b1);
        issue_op(OP_DEX, 8'h00, 1'b0);
        issue_op(OP_INC, 8'hFF, 1'b0);
        issue_op(OP_DEC, 8'h00, 1'b0);
        issue_op(OP_CMP, 8'h00, 1'b0);
        issue_op(OP_BIT, 8'hC0, 1'b0);
        issue_op(OP_BVS, 8'h00, 1'b0);
        issue_op(OP_SPARE_HIGH, 8'hFF, 1'b1);
        issue_op(OP_NOP, 8'hFF, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            pace = pace_t'(phase);
            // sender keeps pushing back-to-back while the result side holds off
            if (pace == PACE_SENDER_BURST)
                long_hold_req = 1'b1;
            repeat (PHASE_WORDS) issue_random_op();
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && outstanding_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
